/* rtl/core/adsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int AMP_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Q1.15 unity.
    localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd3;

    localparam logic [CFG_W-1:0] ATTACK_RST  = 16'd480;
    localparam logic [CFG_W-1:0] DECAY_RST   = 16'd480;
    localparam logic [CFG_W-1:0] SUSTAIN_RST = 16'd16384;
    localparam logic [CFG_W-1:0] RELEASE_RST = 16'd4800;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic prep;
        logic mul;
        logic div_step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_status;

endpackage : adsr_pkg
`default_nettype wire

/* rtl/core/adsr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_ctrl
// Sequencer: takes a tick request, walks the datapath through its steps.
// ----------------------------------------------------------------------------
module adsr_ctrl
    import adsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.need_div ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold the finished result until the output register is free.
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : adsr_ctrl
`default_nettype wire

/* rtl/core/adsr_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_dp
// Envelope datapath: registers, segment select, multiplier, serial divider.
// ----------------------------------------------------------------------------
module adsr_dp
    import adsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_note_start,
    input  wire logic                 i_gate,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [AMP_W-1:0]          o_amplitude,
    output logic                      o_active
);

    typedef enum logic [1:0] {
        FM_DIRECT,
        FM_QUOT,
        FM_BASE_MINUS
    } t_fmode;

    logic [CFG_W-1:0] r_attack, r_decay, r_sustain, r_release;

    logic [COUNT_WIDTH-1:0] r_tick, r_rel_start;
    logic                   r_voice_on, r_in_rel, r_gate;

    logic [15:0]      r_op_a, r_op_b, r_div, r_rem, r_qn;
    logic [AMP_W-1:0] r_base;
    t_fmode           r_fmode;

    logic             r_out_valid, r_out_active;
    logic [AMP_W-1:0] r_out_amp;

    // Effective register values: zero lengths act as one, sustain clamps to unity.
    logic [15:0] a_eff, d_eff, r_eff, s_eff;
    assign a_eff = (r_attack  == '0) ? 16'd1 : r_attack;
    assign d_eff = (r_decay   == '0) ? 16'd1 : r_decay;
    assign r_eff = (r_release == '0) ? 16'd1 : r_release;
    assign s_eff = (r_sustain > AMP_ONE) ? AMP_ONE : r_sustain;

    // Segment selection for the current tick.
    logic                   entering, rel_now;
    logic [COUNT_WIDTH-1:0] rs_eff, elapsed, t_minus_a;
    logic [16:0]            ad_sum;
    logic                   t_lt_a, t_lt_ad;
    logic                   sel_div;
    logic [15:0]            sel_a, sel_b, sel_d;
    logic [AMP_W-1:0]       sel_base;
    t_fmode                 sel_fmode;

    assign entering  = r_voice_on && !r_in_rel && !r_gate;
    assign rel_now   = r_in_rel || entering;
    assign rs_eff    = entering ? r_tick : r_rel_start;
    assign elapsed   = r_tick - rs_eff;
    assign ad_sum    = {1'b0, a_eff} + {1'b0, d_eff};
    assign t_lt_a    = r_tick < COUNT_WIDTH'(a_eff);
    assign t_lt_ad   = r_tick < COUNT_WIDTH'(ad_sum);
    assign t_minus_a = r_tick - COUNT_WIDTH'(a_eff);

    always_comb begin
        sel_div   = 1'b0;
        sel_a     = '0;
        sel_b     = '0;
        sel_d     = 16'd1;
        sel_base  = '0;
        sel_fmode = FM_DIRECT;
        if (!r_voice_on) begin
            sel_base = '0;
        end else if (rel_now) begin
            if ((elapsed >= COUNT_WIDTH'(r_eff)) || (s_eff == '0)) begin
                sel_base = '0;
            end else begin
                sel_div   = 1'b1;
                sel_a     = elapsed[15:0];
                sel_b     = s_eff;
                sel_d     = r_eff;
                sel_base  = s_eff;
                sel_fmode = FM_BASE_MINUS;
            end
        end else if (t_lt_a) begin
            sel_div   = 1'b1;
            sel_a     = r_tick[15:0];
            sel_b     = AMP_ONE;
            sel_d     = a_eff;
            sel_fmode = FM_QUOT;
        end else if (t_lt_ad) begin
            sel_div   = 1'b1;
            sel_a     = t_minus_a[15:0];
            sel_b     = AMP_ONE - s_eff;
            sel_d     = d_eff;
            sel_base  = AMP_ONE;
            sel_fmode = FM_BASE_MINUS;
        end else begin
            sel_base = s_eff;
        end
    end

    // Product stays below divisor times 2^15, so the quotient fits 16 bits.
    logic [31:0] prod;
    assign prod = r_op_a * r_op_b;

    logic [16:0] trial, diff;
    logic        ge;
    assign trial = {r_rem, r_qn[15]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    logic [AMP_W-1:0] fin_amp, out_amp;
    logic             fin_on;
    always_comb begin
        case (r_fmode)
            FM_QUOT:       fin_amp = r_qn;
            FM_BASE_MINUS: fin_amp = r_base - r_qn;
            default:       fin_amp = r_base;
        endcase
    end
    assign fin_on  = r_voice_on && !(r_in_rel && (fin_amp == '0));
    assign out_amp = fin_on ? fin_amp : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= ATTACK_RST;
            r_decay     <= DECAY_RST;
            r_sustain   <= SUSTAIN_RST;
            r_release   <= RELEASE_RST;
            r_tick      <= '0;
            r_rel_start <= '0;
            r_voice_on  <= 1'b0;
            r_in_rel    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ATTACK:  r_attack  <= i_cfg_data;
                    REG_DECAY:   r_decay   <= i_cfg_data;
                    REG_SUSTAIN: r_sustain <= i_cfg_data;
                    REG_RELEASE: r_release <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_note_start) begin
                r_voice_on  <= 1'b1;
                r_in_rel    <= 1'b0;
                r_tick      <= '0;
                r_rel_start <= '0;
            end
            if (i_cmd.prep && r_voice_on) begin
                if (entering) begin
                    r_in_rel    <= 1'b1;
                    r_rel_start <= r_tick;
                end
                if (r_tick != '1) begin
                    r_tick <= r_tick + 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_voice_on  <= fin_on;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_gate <= i_gate;
        end
        if (i_cmd.prep) begin
            r_op_a  <= sel_a;
            r_op_b  <= sel_b;
            r_div   <= sel_d;
            r_base  <= sel_base;
            r_fmode <= sel_fmode;
        end
        if (i_cmd.mul) begin
            r_rem <= prod[31:16];
            r_qn  <= prod[15:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[15:0] : trial[15:0];
            r_qn  <= {r_qn[14:0], ge};
        end
        if (i_cmd.fin) begin
            r_out_amp    <= out_amp;
            r_out_active <= fin_on;
        end
    end

    assign o_status.need_div = sel_div;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_amplitude       = r_out_amp;
    assign o_active          = r_out_active;

endmodule : adsr_dp
`default_nettype wire

/* rtl/core/adsr_envelope_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Linear ADSR envelope generator for one voice, one result per sample tick.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one sample tick carrying a note-start
// flag and a gate level; each tick produces exactly one result on the master
// stream with the Q1.15 amplitude and an active flag.
// The four envelope registers are written through the configuration channel,
// which is always ready; writes are expected only while the block is idle,
// and a write to an index beyond the release register is ignored.
// A tick that needs a ramp value passes through the accept step, a prepare
// step, a 16x16 multiply, the restoring divider (one quotient bit per
// cycle over the sixteen quotient bits) and a finish step before the next
// tick can be accepted.
// Ticks in sustain, in an inactive voice or at the end of a release skip the
// multiplier and divider and go from the prepare step to the finish step.
// A result is registered into the output register by the finish step.
// The result sits in an output register; a new tick is accepted while it
// waits. If the receiver stalls, the sequencer holds the next result in its
// finish step until the output register is freed.
// Synchronous reset restores the default register values and leaves the
// voice inactive with a zero tick count and no pending result.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit
    import adsr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // Tick input stream.
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [0] note_start, [1] gate, rest zero
    // Envelope output stream.
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata   // [15:0] amplitude, [16] active, rest zero
);

    t_cmd             cmd;
    t_status          status;
    logic [AMP_W-1:0] amplitude;
    logic             active;

    // Configuration registers accept a write in any cycle.
    assign o_cfg_ready = 1'b1;

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adsr_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_note_start (i_s_axis_tdata[0]),
        .i_gate       (i_s_axis_tdata[1]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_amplitude  (amplitude),
        .o_active     (active)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - AMP_W - 1){1'b0}}, active, amplitude};

endmodule : adsr_envelope_generator_unit
`default_nettype wire
